// ===== rtl/qypc_pkg.sv =====
// ----------------------------------------------------------------------------
// qypc_pkg: shared types and constants for the quadrature yaw PI controller
// Field widths, operation and register codes, fixed-point constants and the
// Gray-code step table.
// ----------------------------------------------------------------------------
`default_nettype none

package qypc_pkg;

  // Payload field widths.
  localparam int OP_W       = 2;
  localparam int LEVELS_W   = 2;
  localparam int TARGET_W   = 9;
  localparam int ANGLE_W    = 12;
  localparam int EFFORT_W   = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int KP_W       = 18;
  localparam int KI_W       = 24;

  // Internal arithmetic widths.
  localparam int QUO_W      = 11;  // magnitude of tenths (up to 1800) or degrees
  localparam int YAW_W      = 10;  // yaw in degrees, below one turn
  localparam int ERR_W      = 11;  // heading error before and after the wrap
  localparam int P_W        = 30;  // kp * err, before the Q16 alignment
  localparam int I_W        = 36;  // ki_dt * err, Q.32
  localparam int INTEG_W    = 48;  // integrator, signed Q16.32
  localparam int TOTAL_W    = 50;  // full effort sum, Q.32
  localparam int FRAC_W     = 32;
  localparam int P_SHIFT    = 16;  // Q2.16 gain times integer error into Q.32
  localparam int EFF_FULL_W = TOTAL_W - FRAC_W;

  localparam int TENTHS_PER_TURN  = 3600;
  localparam int DEGREES_PER_TURN = 360;

  localparam logic signed [ERR_W-1:0] ERR_HALF = 11'sd180;
  localparam logic signed [ERR_W-1:0] ERR_TURN = 11'sd360;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_REFERENCE = 2'd1,
    OP_TICK      = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN       = 3'd0,
    CFG_KI_DT_GAIN    = 3'd1,
    CFG_EFFORT_OFFSET = 3'd2,
    CFG_EFFORT_MAX    = 3'd3,
    CFG_EFFORT_MIN    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [KP_W-1:0]     kp_gain;
    logic [KI_W-1:0]     ki_dt_gain;
    logic [EFFORT_W-1:0] effort_offset;
    logic [EFFORT_W-1:0] effort_max;
    logic [EFFORT_W-1:0] effort_min;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp_gain:       18'd58327,
    ki_dt_gain:    24'd42950,
    effort_offset: 7'd40,
    effort_max:    7'd70,
    effort_min:    7'd2
  };

  // One step along 00 -> 01 -> 11 -> 10 is +1, the reverse is -1. No change or
  // a jump across both channels gives 0.
  function automatic logic signed [1:0] gray_step(input logic [1:0] prev,
                                                  input logic [1:0] curr);
    logic signed [1:0] s;
    unique case ({prev, curr})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = 2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = -2'sd1;
      default:                            s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qypc_fifo.sv =====
// ----------------------------------------------------------------------------
// qypc_fifo: small register queue
// First-in first-out buffer with full and empty flags and a head that is
// always visible on dout.
// ----------------------------------------------------------------------------
`default_nettype none

module qypc_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          rd,
  output logic [DW-1:0] dout,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qypc_cdiv.sv =====
// ----------------------------------------------------------------------------
// qypc_cdiv: scale by a constant ratio
// Computes floor(x * MUL / DIV) for unsigned x with a reciprocal multiply,
// a register, then one remainder check that corrects the estimate by one.
// ----------------------------------------------------------------------------
`default_nettype none

module qypc_cdiv #(
  parameter int XW  = 10,
  parameter int MUL = 3600,
  parameter int DIV = 448,
  parameter int QW  = 11
) (
  input  logic          clk,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);

  localparam int PRW = XW + $clog2(MUL + 1);
  localparam int SH  = PRW + $clog2(DIV) + 1;
  localparam longint unsigned RECIP  = (64'd1 << SH) / DIV;
  localparam longint unsigned FACTOR = RECIP * MUL;

  logic [63:0]    est_full;
  logic [QW-1:0]  est;
  logic [QW-1:0]  est_r;
  logic [XW-1:0]  x_r;
  logic [PRW-1:0] exact;
  logic [PRW-1:0] approx;
  logic [PRW-1:0] rem;

  // The estimate is never above the true quotient and at most one below it.
  assign est_full = 64'(x) * FACTOR;
  assign est      = est_full[SH +: QW];

  always_ff @(posedge clk) begin
    x_r   <= x;
    est_r <= est;
  end

  assign exact  = PRW'(x_r) * PRW'(MUL);
  assign approx = PRW'(est_r) * PRW'(DIV);
  assign rem    = exact - approx;
  assign q      = est_r + QW'(rem >= PRW'(DIV));

endmodule

`default_nettype wire

// ===== rtl/qypc_front.sv =====
// ----------------------------------------------------------------------------
// qypc_front: encoder front end
// Accepts items, tracks the encoder count, the channel levels and the
// reference flag, and passes one classified entry per item to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qypc_front #(
  parameter int STEPS_PER_TURN = 448,
  parameter int PW             = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [qypc_pkg::OP_W-1:0]           operation,
  input  logic [qypc_pkg::LEVELS_W-1:0]       channels,
  input  logic signed [qypc_pkg::TARGET_W-1:0] target_deg,
  input  logic                                mid_full,
  output logic                                mid_wr,
  output logic                                mid_tick,
  output logic signed [PW-1:0]                mid_pos,
  output logic                                mid_ref,
  output logic signed [qypc_pkg::TARGET_W-1:0] mid_target
);

  import qypc_pkg::*;

  localparam logic signed [PW:0] TURN = (PW + 1)'(STEPS_PER_TURN);

  logic signed [PW-1:0]     position;
  logic signed [PW-1:0]     position_next;
  logic [LEVELS_W-1:0]      last_levels;
  logic [LEVELS_W-1:0]      last_levels_next;
  logic                     ref_flag;
  logic                     ref_flag_next;
  logic                     accept;
  logic                     tick;
  logic signed [PW:0]       moved;

  assign full   = mid_full;
  assign accept = push & ~mid_full;
  assign moved  = (PW + 1)'(position) + (PW + 1)'(gray_step(last_levels, channels));

  always_comb begin
    position_next    = position;
    last_levels_next = last_levels;
    ref_flag_next    = ref_flag;
    tick             = 1'b0;
    unique case (operation)
      OP_SAMPLE: begin
        last_levels_next = channels;
        // A full turn in either direction returns the count to zero.
        if (moved >= TURN || moved <= -TURN) begin
          position_next = '0;
        end else begin
          position_next = PW'(moved);
        end
      end
      OP_REFERENCE: begin
        if (!ref_flag) begin
          position_next = '0;
          ref_flag_next = 1'b1;
        end
      end
      OP_TICK: begin
        tick = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      last_levels <= '0;
      ref_flag    <= 1'b0;
    end else if (accept) begin
      position    <= position_next;
      last_levels <= last_levels_next;
      ref_flag    <= ref_flag_next;
    end
  end

  assign mid_wr     = accept;
  assign mid_tick   = tick;
  assign mid_pos    = position_next;
  assign mid_ref    = ref_flag_next;
  assign mid_target = target_deg;

endmodule

`default_nettype wire

// ===== rtl/qypc_back.sv =====
// ----------------------------------------------------------------------------
// qypc_back: angle scaling and PI controller pipeline
// Four register stages: scale estimate, angle and yaw, gain products, and the
// integrator step. Entries are taken from the middle queue only while the
// result queue has room for everything already in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module qypc_back #(
  parameter int STEPS_PER_TURN = 448,
  parameter int PW             = 10,
  parameter int OUT_DEPTH      = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qypc_pkg::cfg_t                       cfg,
  input  logic                                 mid_empty,
  input  logic                                 mid_tick,
  input  logic signed [PW-1:0]                 mid_pos,
  input  logic                                 mid_ref,
  input  logic signed [qypc_pkg::TARGET_W-1:0] mid_target,
  output logic                                 mid_rd,
  input  logic                                 out_beat,
  output logic                                 res_push,
  output logic signed [PW-1:0]                 res_step,
  output logic signed [qypc_pkg::ANGLE_W-1:0]  res_angle,
  output logic [qypc_pkg::EFFORT_W-1:0]        res_effort,
  output logic                                 res_valid,
  output logic                                 res_ref
);

  import qypc_pkg::*;

  localparam int RW   = $clog2(OUT_DEPTH + 1);
  localparam int HALF = STEPS_PER_TURN / 2;
  localparam logic signed [PW:0] TURN_S = (PW + 1)'(STEPS_PER_TURN);
  localparam logic signed [PW:0] HALF_S = (PW + 1)'(HALF);

  // Result queue credits.
  logic [RW-1:0] reserved;
  logic          take;

  assign take   = ~mid_empty & (reserved != RW'(OUT_DEPTH));
  assign mid_rd = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (take && !out_beat) begin
      reserved <= reserved + 1'b1;
    end else if (out_beat && !take) begin
      reserved <= reserved - 1'b1;
    end
  end

  // Stage 0: half-turn wrap and magnitudes into the constant scalers.
  logic signed [PW:0]  pos_x;
  logic signed [PW:0]  wrap_x;
  logic [PW-1:0]       mag_w;
  logic [PW-1:0]       mag_u;
  logic [QUO_W-1:0]    tenths_q;
  logic [QUO_W-1:0]    deg_q;

  assign pos_x = (PW + 1)'(mid_pos);

  always_comb begin
    if (pos_x > HALF_S) begin
      wrap_x = pos_x - TURN_S;
    end else if (pos_x < -HALF_S) begin
      wrap_x = pos_x + TURN_S;
    end else begin
      wrap_x = pos_x;
    end
  end

  assign mag_w = PW'(wrap_x[PW] ? -wrap_x : wrap_x);
  assign mag_u = PW'(pos_x[PW] ? -pos_x : pos_x);

  qypc_cdiv #(
    .XW (PW),
    .MUL(TENTHS_PER_TURN),
    .DIV(STEPS_PER_TURN),
    .QW (QUO_W)
  ) u_tenths (
    .clk(clk),
    .x  (mag_w),
    .q  (tenths_q)
  );

  // Truncating tenths and then dividing by ten equals one truncating
  // division of the degree product.
  qypc_cdiv #(
    .XW (PW),
    .MUL(DEGREES_PER_TURN),
    .DIV(STEPS_PER_TURN),
    .QW (QUO_W)
  ) u_degrees (
    .clk(clk),
    .x  (mag_u),
    .q  (deg_q)
  );

  // Stage 1.
  logic                        v1;
  logic                        tick1;
  logic signed [PW-1:0]        pos1;
  logic                        ref1;
  logic signed [TARGET_W-1:0]  tgt1;
  logic                        negw1;
  logic                        negu1;

  // Stage 2.
  logic                        v2;
  logic                        tick2;
  logic signed [PW-1:0]        pos2;
  logic                        ref2;
  logic signed [TARGET_W-1:0]  tgt2;
  logic signed [ANGLE_W-1:0]   angle2;
  logic signed [YAW_W-1:0]     yaw2;

  // Stage 3.
  logic                        v3;
  logic                        tick3;
  logic signed [PW-1:0]        pos3;
  logic                        ref3;
  logic signed [TARGET_W-1:0]  tgt3;
  logic signed [ANGLE_W-1:0]   angle3;
  logic signed [P_W-1:0]       p3;
  logic signed [I_W-1:0]       i3;

  // Stage 4.
  logic                        v4;
  logic                        tick4;
  logic signed [PW-1:0]        pos4;
  logic                        ref4;
  logic signed [ANGLE_W-1:0]   angle4;
  logic signed [TOTAL_W-1:0]   total4;

  // Controller state.
  logic signed [INTEG_W-1:0]   integ;
  logic signed [TARGET_W-1:0]  last_target;
  logic [EFFORT_W-1:0]         last_effort;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    tick1 <= mid_tick;
    pos1  <= mid_pos;
    ref1  <= mid_ref;
    tgt1  <= mid_target;
    negw1 <= wrap_x[PW];
    negu1 <= pos_x[PW];
  end

  // Stage 1 to 2: restore signs.
  always_ff @(posedge clk) begin
    tick2  <= tick1;
    pos2   <= pos1;
    ref2   <= ref1;
    tgt2   <= tgt1;
    angle2 <= negw1 ? -ANGLE_W'(tenths_q) : ANGLE_W'(tenths_q);
    yaw2   <= negu1 ? -YAW_W'(deg_q) : YAW_W'(deg_q);
  end

  // Stage 2 to 3: shortest-path error and the two gain products.
  logic signed [ERR_W-1:0] err_raw;
  logic signed [ERR_W-1:0] err;
  logic signed [P_W-1:0]   kp_x;
  logic signed [P_W-1:0]   err_p;
  logic signed [I_W-1:0]   ki_x;
  logic signed [I_W-1:0]   err_i;

  assign err_raw = ERR_W'(yaw2) - ERR_W'(tgt2);

  always_comb begin
    if (err_raw > ERR_HALF) begin
      err = err_raw - ERR_TURN;
    end else if (err_raw < -ERR_HALF) begin
      err = err_raw + ERR_TURN;
    end else begin
      err = err_raw;
    end
  end

  assign kp_x  = P_W'(cfg.kp_gain);
  assign err_p = P_W'(err);
  assign ki_x  = I_W'(cfg.ki_dt_gain);
  assign err_i = I_W'(err);

  always_ff @(posedge clk) begin
    tick3  <= tick2;
    pos3   <= pos2;
    ref3   <= ref2;
    tgt3   <= tgt2;
    angle3 <= angle2;
    p3     <= kp_x * err_p;
    i3     <= ki_x * err_i;
  end

  // Stage 3 to 4: a new setpoint restarts the integrator before this tick
  // uses it; the sum is exact in Q.32.
  logic                         clear;
  logic signed [INTEG_W-1:0]    integ_base;
  logic signed [INTEG_W:0]      integ_sum;
  logic signed [INTEG_W-1:0]    integ_sat;
  logic signed [TOTAL_W-1:0]    p_aligned;
  logic signed [TOTAL_W-1:0]    off_aligned;
  logic signed [TOTAL_W-1:0]    total;

  assign clear       = (tgt3 != last_target);
  assign integ_base  = clear ? '0 : integ;
  assign p_aligned   = TOTAL_W'(p3) <<< P_SHIFT;
  assign off_aligned = TOTAL_W'(cfg.effort_offset) << FRAC_W;
  assign total       = p_aligned + TOTAL_W'(integ_base) + TOTAL_W'(i3) + off_aligned;
  assign integ_sum   = (INTEG_W + 1)'(integ_base) + (INTEG_W + 1)'(i3);

  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = INTEG_W'(integ_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ       <= '0;
      last_target <= '0;
    end else if (v3 && tick3) begin
      integ       <= integ_sat;
      last_target <= tgt3;
    end
  end

  always_ff @(posedge clk) begin
    tick4  <= tick3;
    pos4   <= pos3;
    ref4   <= ref3;
    angle4 <= angle3;
    total4 <= total;
  end

  // Stage 4: truncate toward zero and clamp.
  logic signed [EFF_FULL_W-1:0] eff_floor;
  logic signed [EFF_FULL_W-1:0] eff_int;
  logic signed [EFF_FULL_W-1:0] max_x;
  logic signed [EFF_FULL_W-1:0] min_x;
  logic                         round_up;
  logic [EFFORT_W-1:0]          eff_clamped;

  assign eff_floor = $signed(total4[TOTAL_W-1:FRAC_W]);
  assign round_up  = total4[TOTAL_W-1] & (|total4[FRAC_W-1:0]);
  assign eff_int   = eff_floor + EFF_FULL_W'(round_up);
  assign max_x     = EFF_FULL_W'(cfg.effort_max);
  assign min_x     = EFF_FULL_W'(cfg.effort_min);

  always_comb begin
    priority if (eff_int > max_x) begin
      eff_clamped = cfg.effort_max;
    end else if (eff_int < min_x) begin
      eff_clamped = cfg.effort_min;
    end else begin
      eff_clamped = EFFORT_W'(eff_int);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_effort <= '0;
    end else if (v4 && tick4) begin
      last_effort <= eff_clamped;
    end
  end

  assign res_push   = v4;
  assign res_step   = pos4;
  assign res_angle  = angle4;
  assign res_effort = tick4 ? eff_clamped : last_effort;
  assign res_valid  = tick4;
  assign res_ref    = ref4;

endmodule

`default_nettype wire

// ===== rtl/quadrature_yaw_pi_controller.sv =====
// A result beat passes through the middle queue, the back-end register stages and
// the result queue. Throughput: one beat per cycle each way unless full or empty
// holds it; neither the front-end count loop nor the integrator loop stalls it.
// A stalled result side fills the 8-entry result queue, then the 4-entry middle
// queue, and only then raises full.
// Reset (rst, synchronous) empties both queues and restores all state.
// ----------------------------------------------------------------------------
// quadrature_yaw_pi_controller: encoder decoder with a PI yaw controller
// Decodes quadrature encoder samples into a step count and yaw angle, and on
// each control tick forms a clamped PI drive effort toward a yaw setpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_yaw_pi_controller #(
  parameter int STEPS_PER_TURN = 448
) (
  input  logic                                   clk,
  input  logic                                   rst,

  // Input queue side.
  input  logic                                   push,
  output logic                                   full,
  input  logic [qypc_pkg::OP_W-1:0]              operation,
  input  logic [qypc_pkg::LEVELS_W-1:0]          channels,
  input  logic signed [qypc_pkg::TARGET_W-1:0]   target_deg,

  // Result queue side.
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [$clog2(STEPS_PER_TURN):0] step_count,
  output logic signed [qypc_pkg::ANGLE_W-1:0]    angle_tenths,
  output logic [qypc_pkg::EFFORT_W-1:0]          drive_effort,
  output logic                                   effort_valid,
  output logic                                   reference_seen,

  // Register writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qypc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qypc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import qypc_pkg::*;

  // The step count must hold anything strictly inside one turn either way.
  localparam int PW        = $clog2(STEPS_PER_TURN) + 1;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int MID_W     = 1 + PW + 1 + TARGET_W;
  localparam int OUT_W     = PW + ANGLE_W + EFFORT_W + 2;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken. The gains and bounds must
  // only be changed while no beat is in flight, which the block itself does not
  // enforce, so that the pipeline can read them directly.
  // --------------------------------------------------------------------------
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KP_GAIN:       cfg.kp_gain       <= KP_W'(cfg_data);
        CFG_KI_DT_GAIN:    cfg.ki_dt_gain    <= KI_W'(cfg_data);
        CFG_EFFORT_OFFSET: cfg.effort_offset <= EFFORT_W'(cfg_data);
        CFG_EFFORT_MAX:    cfg.effort_max    <= EFFORT_W'(cfg_data);
        CFG_EFFORT_MIN:    cfg.effort_min    <= EFFORT_W'(cfg_data);
        default: begin
          // Indexes past the register list are accepted and dropped.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: the encoder count, channel levels and reference flag update in
  // the cycle a beat is accepted. Each beat leaves one entry in the middle
  // queue carrying the count after the beat, so the back end never has to
  // look back at encoder state.
  // --------------------------------------------------------------------------
  logic                       mid_full;
  logic                       mid_wr;
  logic                       mid_tick;
  logic signed [PW-1:0]       mid_pos;
  logic                       mid_ref;
  logic signed [TARGET_W-1:0] mid_target;

  qypc_front #(
    .STEPS_PER_TURN(STEPS_PER_TURN),
    .PW            (PW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .channels  (channels),
    .target_deg(target_deg),
    .mid_full  (mid_full),
    .mid_wr    (mid_wr),
    .mid_tick  (mid_tick),
    .mid_pos   (mid_pos),
    .mid_ref   (mid_ref),
    .mid_target(mid_target)
  );

  // --------------------------------------------------------------------------
  // Middle queue: decouples encoder tracking from the controller pipeline.
  // --------------------------------------------------------------------------
  logic [MID_W-1:0]           mid_din;
  logic [MID_W-1:0]           mid_dout;
  logic                       mid_empty;
  logic                       mid_rd;
  logic                       q_tick;
  logic signed [PW-1:0]       q_pos;
  logic                       q_ref;
  logic signed [TARGET_W-1:0] q_target;

  assign mid_din = {mid_tick, mid_pos, mid_ref, mid_target};
  assign {q_tick, q_pos, q_ref, q_target} = mid_dout;

  qypc_fifo #(
    .DW   (MID_W),
    .DEPTH(MID_DEPTH)
  ) u_midq (
    .clk  (clk),
    .rst  (rst),
    .wr   (mid_wr),
    .din  (mid_din),
    .full (mid_full),
    .rd   (mid_rd),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  // --------------------------------------------------------------------------
  // Back end: angle scaling, error, gain products, integrator and clamp. It
  // never stalls once an entry is taken; the credit count inside it keeps the
  // result queue from overflowing.
  // --------------------------------------------------------------------------
  logic                      out_beat;
  logic                      res_push;
  logic signed [PW-1:0]      res_step;
  logic signed [ANGLE_W-1:0] res_angle;
  logic [EFFORT_W-1:0]       res_effort;
  logic                      res_valid;
  logic                      res_ref;

  assign out_beat = pop & ~empty;

  qypc_back #(
    .STEPS_PER_TURN(STEPS_PER_TURN),
    .PW            (PW),
    .OUT_DEPTH     (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_tick  (q_tick),
    .mid_pos   (q_pos),
    .mid_ref   (q_ref),
    .mid_target(q_target),
    .mid_rd    (mid_rd),
    .out_beat  (out_beat),
    .res_push  (res_push),
    .res_step  (res_step),
    .res_angle (res_angle),
    .res_effort(res_effort),
    .res_valid (res_valid),
    .res_ref   (res_ref)
  );

  // --------------------------------------------------------------------------
  // Result queue: the head is presented on the result ports while empty is
  // low. Its full flag is unused because the back end holds a credit for
  // every entry it may write.
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] out_din;
  logic [OUT_W-1:0] out_dout;
  logic             out_full;

  assign out_din = {res_step, res_angle, res_effort, res_valid, res_ref};
  assign {step_count, angle_tenths, drive_effort, effort_valid, reference_seen} = out_dout;

  qypc_fifo #(
    .DW   (OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .din  (out_din),
    .full (out_full),
    .rd   (pop),
    .dout (out_dout),
    .empty(empty)
  );

  // The credit scheme guarantees the queue never refuses a write; surfacing
  // the flag here keeps it visible in waveforms next to res_push.
  logic out_overrun;
  assign out_overrun = res_push & out_full;

  logic unused_ok;
  assign unused_ok = out_overrun;

endmodule

`default_nettype wire

// ===== rtl/qypc_checker.sv =====
// ----------------------------------------------------------------------------
// qypc_checker: port-level checks for the quadrature yaw PI controller
// Watches the result side over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qypc_checker #(
  parameter int STEPS_PER_TURN = 448
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   empty,
  input logic                                   pop,
  input logic signed [$clog2(STEPS_PER_TURN):0] step_count,
  input logic signed [qypc_pkg::ANGLE_W-1:0]    angle_tenths,
  input logic [qypc_pkg::EFFORT_W-1:0]          drive_effort,
  input logic                                   effort_valid,
  input logic                                   reference_seen
);

  logic                            beat;
  logic                            seen_ref;
  logic [qypc_pkg::EFFORT_W-1:0]   prev_effort;

  assign beat = pop & ~empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ref    <= 1'b0;
      prev_effort <= '0;
    end else if (beat) begin
      seen_ref    <= seen_ref | reference_seen;
      prev_effort <= drive_effort;
    end
  end

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // A waiting result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(step_count) && $stable(angle_tenths)
                            && $stable(drive_effort)))
    else $error("waiting result changed before it was taken");

  // Once a reference pulse has been reported it is reported on every later beat.
  a_ref_sticky: assert property (@(posedge clk) disable iff (rst)
      (!empty && seen_ref) |-> reference_seen)
    else $error("reference_seen dropped after being reported");

  // Beats that are not control ticks repeat the effort of the previous beat.
  a_effort_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !effort_valid) |-> (drive_effort == prev_effort))
    else $error("drive_effort changed on a beat without a control tick");

endmodule

bind quadrature_yaw_pi_controller qypc_checker #(
  .STEPS_PER_TURN(STEPS_PER_TURN)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .step_count    (step_count),
  .angle_tenths  (angle_tenths),
  .drive_effort  (drive_effort),
  .effort_valid  (effort_valid),
  .reference_seen(reference_seen)
);

`default_nettype wire

// ===== test/quadrature_yaw_pi_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_yaw_pi_controller_tb: self-checking regression for the yaw block
// Drives encoder samples, reference pulses and control ticks through the input
// queue and compares every result beat with a cycle-free model of the decoder
// and the PI loop. The run covers several register settings and random idling.
// ----------------------------------------------------------------------------

module quadrature_yaw_pi_controller_tb;
  import qypc_pkg::*;

  localparam int STEPS_PER_TURN = 448;
  localparam int COUNT_W        = $clog2(STEPS_PER_TURN) + 1;
  localparam int RESULT_LATENCY = 5;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int PHASES         = 5;
  localparam int DIRECTED_ROWS  = 21;

  // The fourth operation code has no function; the block must only report state.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Q.32 scaling and the signed 48-bit integrator bounds, held in 64 bits.
  localparam longint Q32_ONE      = 64'sd1 <<< 32;
  localparam longint INTEG_TOP    = (64'sd1 <<< 47) - 64'sd1;
  localparam longint INTEG_BOTTOM = -(64'sd1 <<< 47);

  // One result beat as it appears on the result ports.
  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic signed [ANGLE_W-1:0] angle;
    logic [EFFORT_W-1:0]       effort;
    logic                      tick;
    logic                      seen;
  } yaw_beat_t;

  // One row of the directed table. When typed is set, want holds the result
  // read straight off the specification and replaces the computed one.
  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic [LEVELS_W-1:0]        levels;
    logic signed [TARGET_W-1:0] target;
    logic                       typed;
    yaw_beat_t                  want;
  } stim_row_t;

  // Directed rows run under the reset gains: kp 0.89, offset 40, clamp [2, 70].
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Unused code straight after reset: everything reads zero.
    '{OP_UNUSED,    2'b00, 9'sd0,    1'b1, '{10'sd0, 12'sd0, 7'd0, 1'b0, 1'b0}},
    // Forward steps, then a jump across both channels, a repeated level and a step back.
    '{OP_SAMPLE,    2'b01, 9'sd0,    1'b1, '{10'sd1, 12'sd8, 7'd0, 1'b0, 1'b0}},
    '{OP_SAMPLE,    2'b11, 9'sd0,    1'b0, '0},
    '{OP_SAMPLE,    2'b00, 9'sd0,    1'b0, '0},
    '{OP_SAMPLE,    2'b00, 9'sd0,    1'b0, '0},
    '{OP_SAMPLE,    2'b10, 9'sd0,    1'b0, '0},
    // Zero error at an unchanged setpoint gives the bare offset.
    '{OP_TICK,      2'b00, 9'sd0,    1'b1, '{10'sd1, 12'sd8, 7'd40, 1'b1, 1'b0}},
    // First reference pulse zeroes the count; its channel levels are ignored.
    '{OP_REFERENCE, 2'b11, 9'sd0,    1'b1, '{10'sd0, 12'sd0, 7'd40, 1'b0, 1'b1}},
    '{OP_SAMPLE,    2'b11, 9'sd0,    1'b0, '0},
    // A later reference pulse leaves the count alone.
    '{OP_REFERENCE, 2'b00, 9'sd0,    1'b1, '{-10'sd1, -12'sd8, 7'd40, 1'b0, 1'b1}},
    // Setpoint extremes: the effort hits the lower clamp, then the upper one.
    '{OP_TICK,      2'b00, 9'sd180,  1'b1, '{-10'sd1, -12'sd8, 7'd2, 1'b1, 1'b1}},
    '{OP_TICK,      2'b00, -9'sd179, 1'b1, '{-10'sd1, -12'sd8, 7'd70, 1'b1, 1'b1}},
    // Setpoints beyond the legal range still get a single wrap of the error.
    '{OP_TICK,      2'b00, -9'sd256, 1'b0, '0},
    '{OP_TICK,      2'b11, 9'sd255,  1'b0, '0},
    '{OP_TICK,      2'b01, 9'sd255,  1'b0, '0},
    '{OP_UNUSED,    2'b11, -9'sd1,   1'b0, '0},
    '{OP_SAMPLE,    2'b10, 9'sd0,    1'b0, '0},
    '{OP_SAMPLE,    2'b01, 9'sd0,    1'b0, '0},
    '{OP_SAMPLE,    2'b11, 9'sd0,    1'b0, '0},
    '{OP_TICK,      2'b00, -9'sd1,   1'b0, '0},
    '{OP_TICK,      2'b00, 9'sd0,    1'b0, '0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [OP_W-1:0]            operation = '0;
  logic [LEVELS_W-1:0]        channels = '0;
  logic signed [TARGET_W-1:0] target_deg = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [COUNT_W-1:0]  step_count;
  logic signed [ANGLE_W-1:0]  angle_tenths;
  logic [EFFORT_W-1:0]        drive_effort;
  logic                       effort_valid;
  logic                       reference_seen;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Register copies used by the predictor.
  longint kp_q16;
  longint ki_dt_q32;
  int     offset_pct;
  int     max_pct;
  int     min_pct;

  // Predictor state: encoder count, last levels, reference flag and PI loop.
  int                  track_pos;
  logic [LEVELS_W-1:0] prev_levels;
  logic                ref_taken;
  longint              integ_q32;
  int                  held_target;
  logic [EFFORT_W-1:0] held_effort;

  // Results computed at input acceptance, oldest first.
  yaw_beat_t pending_beats[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int accepted_items = 0;
  // Upper bounds for the idle draws of each side, changed from stretch to stretch.
  int gap_cap = 5;
  int stall_cap = 5;

  quadrature_yaw_pi_controller #(
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .channels      (channels),
    .target_deg    (target_deg),
    .empty         (empty),
    .pop           (pop),
    .step_count    (step_count),
    .angle_tenths  (angle_tenths),
    .drive_effort  (drive_effort),
    .effort_valid  (effort_valid),
    .reference_seen(reference_seen),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quadrature_yaw_pi_controller regression: fail");
      $finish;
    end
  end

  // Position of a level pair along the forward Gray order 00, 01, 11, 10.
  function automatic int gray_index(input logic [LEVELS_W-1:0] levels);
    return int'({levels[1], ^levels});
  endfunction

  function automatic logic [LEVELS_W-1:0] gray_levels(input int idx);
    logic [LEVELS_W-1:0] bin;
    bin = 2'(idx);
    return bin ^ (bin >> 1);
  endfunction

  task automatic reset_yaw_model();
    kp_q16      = 58327;
    ki_dt_q32   = 42950;
    offset_pct  = 40;
    max_pct     = 70;
    min_pct     = 2;
    track_pos   = 0;
    prev_levels = '0;
    ref_taken   = 1'b0;
    integ_q32   = 0;
    held_target = 0;
    held_effort = '0;
  endtask

  // Applies one input beat to the predictor state and returns the result beat
  // the block must produce for it.
  function automatic yaw_beat_t advance_yaw_model(input logic [OP_W-1:0] op,
                                                  input logic [LEVELS_W-1:0] levels,
                                                  input logic signed [TARGET_W-1:0] target);
    yaw_beat_t beat;
    int        delta;
    int        wrapped;
    int        yaw_deg;
    int        err;
    int        tgt;
    longint    p_part;
    longint    i_part;
    longint    sum_q32;
    longint    eff;
    beat = '0;
    tgt = int'(target);
    case (op)
      OP_SAMPLE: begin
        // One Gray step forward is +1, backward -1; no change or a jump is 0.
        delta = (gray_index(levels) - gray_index(prev_levels)) & 3;
        if (delta == 1) begin
          track_pos = track_pos + 1;
        end else if (delta == 3) begin
          track_pos = track_pos - 1;
        end
        prev_levels = levels;
        if (track_pos >= STEPS_PER_TURN || track_pos <= -STEPS_PER_TURN) begin
          track_pos = 0;
        end
      end
      OP_REFERENCE: begin
        if (!ref_taken) begin
          track_pos = 0;
          ref_taken = 1'b1;
        end
      end
      OP_TICK: begin
        // Yaw in whole degrees from the unwrapped count, each step truncated.
        yaw_deg = ((track_pos * 3600) / STEPS_PER_TURN) / 10;
        err = yaw_deg - tgt;
        if (err > 180) begin
          err = err - 360;
        end else if (err < -180) begin
          err = err + 360;
        end
        if (tgt != held_target) begin
          integ_q32   = 0;
          held_target = tgt;
        end
        p_part  = kp_q16 * err * 65536;
        i_part  = ki_dt_q32 * err;
        sum_q32 = p_part + integ_q32 + i_part + longint'(offset_pct) * Q32_ONE;
        eff = sum_q32 / Q32_ONE;
        if (eff > max_pct) begin
          eff = max_pct;
        end else if (eff < min_pct) begin
          eff = min_pct;
        end
        held_effort = eff[EFFORT_W-1:0];
        integ_q32 = integ_q32 + i_part;
        if (integ_q32 > INTEG_TOP) begin
          integ_q32 = INTEG_TOP;
        end else if (integ_q32 < INTEG_BOTTOM) begin
          integ_q32 = INTEG_BOTTOM;
        end
        beat.tick = 1'b1;
      end
      default: begin
      end
    endcase
    // The reported angle folds the count into the nearer half turn first.
    wrapped = track_pos;
    if (wrapped > STEPS_PER_TURN / 2) begin
      wrapped = wrapped - STEPS_PER_TURN;
    end else if (wrapped < -(STEPS_PER_TURN / 2)) begin
      wrapped = wrapped + STEPS_PER_TURN;
    end
    beat.count  = COUNT_W'(track_pos);
    beat.angle  = ANGLE_W'((wrapped * 3600) / STEPS_PER_TURN);
    beat.effort = held_effort;
    beat.seen   = ref_taken;
    return beat;
  endfunction

  // Offers one input beat after a random gap and records its expected result
  // once the block takes it. Push stays high between back-to-back beats.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic [LEVELS_W-1:0] levels,
                           input logic signed [TARGET_W-1:0] target,
                           input logic typed,
                           input yaw_beat_t want);
    int        gap;
    yaw_beat_t beat;
    gap = $urandom_range(0, gap_cap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    operation  <= op;
    channels   <= levels;
    target_deg <= target;
    do @(posedge clk); while (full !== 1'b0);
    beat = advance_yaw_model(op, levels, target);
    pending_beats.push_back(typed ? want : beat);
    if (op != OP_UNUSED) begin
      accepted_items++;
    end
  endtask

  // Holds the input side until every pending result has come out and the
  // pipeline has had time to settle.
  task automatic wait_until_idle();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  // Valid stays high across a run of writes; the caller lowers it at the end.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_KP_GAIN:       kp_q16     = longint'(value[KP_W-1:0]);
      CFG_KI_DT_GAIN:    ki_dt_q32  = longint'(value[KI_W-1:0]);
      CFG_EFFORT_OFFSET: offset_pct = int'(value[EFFORT_W-1:0]);
      CFG_EFFORT_MAX:    max_pct    = int'(value[EFFORT_W-1:0]);
      CFG_EFFORT_MIN:    min_pct    = int'(value[EFFORT_W-1:0]);
      default: begin
      end
    endcase
  endtask

  task automatic load_gains(input logic [CFG_DATA_W-1:0] kp,
                            input logic [CFG_DATA_W-1:0] ki,
                            input logic [CFG_DATA_W-1:0] offset,
                            input logic [CFG_DATA_W-1:0] top,
                            input logic [CFG_DATA_W-1:0] bottom);
    wait_until_idle();
    write_reg(CFG_KP_GAIN, kp);
    write_reg(CFG_KI_DT_GAIN, ki);
    write_reg(CFG_EFFORT_OFFSET, offset);
    write_reg(CFG_EFFORT_MAX, top);
    write_reg(CFG_EFFORT_MIN, bottom);
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal setpoints, with a share from the whole 9-bit field.
  function automatic logic signed [TARGET_W-1:0] pick_target();
    if ($urandom_range(0, 6) == 0) begin
      return TARGET_W'($urandom_range(0, 511));
    end
    return TARGET_W'(int'($urandom_range(0, 359)) - 179);
  endfunction

  // Walks the encoder along the Gray order with control ticks mixed in. A
  // broken walk also repeats levels or jumps across both channels.
  task automatic gray_run(input int len, input int dir, input logic broken);
    logic [LEVELS_W-1:0] lv;
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(OP_TICK, 2'($urandom_range(0, 3)), pick_target(), 1'b0, '0);
      end
      lv = gray_levels((gray_index(prev_levels) + 4 + dir) % 4);
      if (broken && $urandom_range(0, 3) == 0) begin
        lv = $urandom_range(0, 1) ? (prev_levels ^ 2'b11) : prev_levels;
      end
      send_item(OP_SAMPLE, lv, pick_target(), 1'b0, '0);
    end
  endtask

  // One random stretch of stimulus with its own idling pattern.
  task automatic random_stretch(input int heading);
    int               kind;
    int               dir;
    int               pick;
    logic [OP_W-1:0]  op;
    logic signed [TARGET_W-1:0] tgt;
    case ($urandom_range(0, 4))
      0: begin gap_cap = 5; stall_cap = 5; end
      1: begin gap_cap = 0; stall_cap = 0; end
      2: begin gap_cap = 0; stall_cap = 5; end
      3: begin gap_cap = 5; stall_cap = 0; end
      default: begin gap_cap = 2; stall_cap = 2; end
    endcase
    // Now and then the sender waits for the result side to run dry.
    if ($urandom_range(0, 29) == 0) begin
      wait_until_idle();
    end
    kind = $urandom_range(0, 99);
    dir = ($urandom_range(0, 3) != 0) ? heading : -heading;
    if (kind < 55) begin
      gray_run($urandom_range(1, 48), dir, 1'b0);
    end else if (kind < 70) begin
      // Noise: any operation code with arbitrary levels and setpoints.
      repeat ($urandom_range(1, 16)) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          op = OP_SAMPLE;
        end else if (pick < 15) begin
          op = OP_TICK;
        end else if (pick < 17) begin
          op = OP_REFERENCE;
        end else begin
          op = OP_UNUSED;
        end
        send_item(op, 2'($urandom_range(0, 3)), TARGET_W'($urandom_range(0, 511)),
                  1'b0, '0);
      end
    end else if (kind < 90) begin
      // Tick bursts mostly hold the setpoint so the integrator builds up.
      tgt = pick_target();
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          tgt = pick_target();
        end
        send_item(OP_TICK, 2'($urandom_range(0, 3)), tgt, 1'b0, '0);
      end
    end else begin
      gray_run($urandom_range(1, 32), dir, 1'b1);
    end
  endtask

  // Compares the beat on the result ports with the oldest expectation.
  task automatic check_beat();
    yaw_beat_t want;
    if (pending_beats.size() == 0) begin
      $error("result beat arrived with no expected result pending");
      mismatch_count++;
    end else begin
      want = pending_beats.pop_front();
      if (step_count !== want.count) begin
        $error("step_count: expected %0d, got %0d", $signed(want.count), step_count);
        mismatch_count++;
      end
      if (angle_tenths !== want.angle) begin
        $error("angle_tenths: expected %0d, got %0d", $signed(want.angle), angle_tenths);
        mismatch_count++;
      end
      if (drive_effort !== want.effort) begin
        $error("drive_effort: expected %0d, got %0d", want.effort, drive_effort);
        mismatch_count++;
      end
      if (effort_valid !== want.tick) begin
        $error("effort_valid: expected %0d, got %0d", want.tick, effort_valid);
        mismatch_count++;
      end
      if (reference_seen !== want.seen) begin
        $error("reference_seen: expected %0d, got %0d", want.seen, reference_seen);
        mismatch_count++;
      end
    end
  endtask

  // Result side: stalls a random number of cycles before each beat, keeping
  // pop high through back-to-back beats.
  task automatic drain_results();
    int stall;
    forever begin
      stall = $urandom_range(0, stall_cap);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      check_beat();
    end
  endtask

  initial begin
    int random_base;
    int heading;
    reset_yaw_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Directed table under the reset register values.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].op, DIRECTED[r].levels, DIRECTED[r].target,
                DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random phases, each under its own register setting. Every setting is
    // loaded only once the block has gone quiet.
    random_base = accepted_items;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        // Largest gains, full offset and the widest clamp.
        0: load_gains(24'd262143, 24'd16777215, 24'd100, 24'd100, 24'd0);
        // All registers zero: the effort is pinned at zero.
        1: load_gains(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        // Crossed clamp bounds, with the lower bound above the upper one.
        2: load_gains(24'($urandom_range(0, 262143)), 24'($urandom_range(0, 16777215)),
                      24'($urandom_range(0, 100)), 24'd20, 24'd80);
        3: load_gains(24'($urandom_range(0, 262143)), 24'($urandom_range(0, 16777215)),
                      24'($urandom_range(0, 100)), 24'($urandom_range(0, 100)),
                      24'($urandom_range(0, 100)));
        default: load_gains(24'd131071, 24'h555555, 24'd91, 24'd95, 24'd27);
      endcase
      heading = $urandom_range(0, 1) ? 1 : -1;
      // A full turn each way carries the count through both half-turn folds
      // of the angle and through the zeroing at one whole turn.
      if (phase == 0) begin
        gray_run(STEPS_PER_TURN + 4, 1, 1'b0);
      end else if (phase == 2) begin
        gray_run(STEPS_PER_TURN + 4, -1, 1'b0);
      end
      while (accepted_items < random_base + (phase + 1) * RANDOM_ITEMS / PHASES) begin
        random_stretch(heading);
      end
    end

    wait_until_idle();
    repeat (RESULT_LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quadrature_yaw_pi_controller regression: pass");
    end else begin
      $display("quadrature_yaw_pi_controller regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qypc_pkg.sv
rtl/qypc_fifo.sv
rtl/qypc_cdiv.sv
rtl/qypc_front.sv
rtl/qypc_back.sv
rtl/quadrature_yaw_pi_controller.sv
rtl/qypc_checker.sv
test/quadrature_yaw_pi_controller_tb.sv
